// ===== hdl/skat_pkg.sv =====
// ----------------------------------------------------------------------------
// skat_pkg
// Shared types and constants for the sorted key accumulate table.
// ----------------------------------------------------------------------------
package skat_pkg;

   localparam int CAPACITY_DEFAULT  = 4096;
   localparam int KEY_BYTES_DEFAULT = 4;

   localparam int KEY_FIELD_W = 32;
   localparam int VAL_W       = 32;
   localparam int IDX_W       = 12;
   localparam int POS_W       = 12;
   localparam int USED_W      = 13;
   localparam int STATUS_W    = 2;

   localparam logic KIND_INCLUDE = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_SHIFT,
      ST_INSERT,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0] out_key;
      logic [VAL_W-1:0]       out_value;
      logic [POS_W-1:0]       position;
      logic                   existed;
      status_type             status;
   } result_type;

endpackage

// ===== hdl/sorted_key_accumulate_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_accumulate_table
// Sorted key table with signed per-key counts, binary search and ordered
// insert over one simple dual-port memory.
// ----------------------------------------------------------------------------
// Keys are held in ascending unsigned order with a wrapping 32-bit count each.
// An include beat binary-searches the used entries; each probe is a memory
// read, then a compare. A miss then shifts the entries at and above the
// insertion point up by one, one entry per cycle through the memory's read
// and write ports, then writes the new entry in its place. A full table
// refuses the insert after the search. A read beat takes the memory read
// through the read state; an out-of-range read goes straight to its result.
// One beat is worked on at a time; the next is taken while a result waits
// in the output register. The table contents after reset are undefined;
// only entries below the used count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_accumulate_table
   import skat_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEFAULT,
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // key[31:0], amount[63:32], index[75:64], zero pad
   input  logic [0:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata   // out_key[31:0], out_value[63:32], position[75:64],
                                   // existed[76], entries_used[89:77], status[91:90], pad
);

   localparam int KEY_W = (8 * KEY_BYTES > KEY_FIELD_W) ? KEY_FIELD_W : 8 * KEY_BYTES;
   localparam int ENT_W = KEY_W + VAL_W;
   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int IW    = (CW > IDX_W) ? CW : IDX_W;

   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   amt_ff, amt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic [AW-1:0]      waddr_ff, waddr_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      count_ff, count_in;
   result_type         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENT_W-1:0]   mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic [ENT_W-1:0]   mem_rdata;

   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_val;
   logic [KEY_W-1:0]   req_key;
   logic [VAL_W-1:0]   req_amt;
   logic [IDX_W-1:0]   req_idx;
   logic               req_in_range;
   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid_full;
   logic               rsp_free;

   assign req_key      = req_tdata[KEY_W-1:0];
   assign req_amt      = req_tdata[63:32];
   assign req_idx      = req_tdata[75:64];
   assign req_in_range = IW'(req_idx) < IW'(count_ff);
   assign rd_key       = mem_rdata[ENT_W-1:VAL_W];
   assign rd_val       = mem_rdata[VAL_W-1:0];
   assign mid_sum      = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid_full     = mid_sum[CW-1:0];
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   skat_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == KIND_READ) begin
                  state_in = req_in_range ? ST_READ : ST_DONE;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               state_in = ST_CMP;
            end else if (count_ff == CW'(CAPACITY)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_CMP: begin
            state_in = (rd_key == key_ff) ? ST_DONE : ST_PROBE;
         end
         ST_SHIFT: begin
            if (ptr_ff == lo_ff && !pend_ff) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: state_in = ST_DONE;
         ST_READ:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      key_in       = key_ff;
      amt_in       = amt_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      mid_in       = mid_ff;
      waddr_in     = waddr_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = waddr_ff;
      mem_wdata    = mem_rdata;
      mem_raddr    = mid_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            key_in     = req_key;
            amt_in     = req_amt;
            idx_in     = req_idx;
            lo_in      = '0;
            hi_in      = count_ff;
            mem_raddr  = AW'(req_idx);
            res_in     = '{out_key: '0, out_value: '0, position: POS_W'(req_idx),
                           existed: 1'b0, status: STATUS_RANGE};
         end
         ST_PROBE: begin
            mem_raddr = AW'(mid_full);
            mid_in    = AW'(mid_full);
            ptr_in    = count_ff;
            pend_in   = 1'b0;
            res_in    = '{out_key: KEY_FIELD_W'(key_ff), out_value: '0,
                          position: POS_W'(lo_ff), existed: 1'b0, status: STATUS_FULL};
         end
         ST_CMP: begin
            if (rd_key == key_ff) begin
               mem_we    = 1'b1;
               mem_waddr = mid_ff;
               mem_wdata = {key_ff, rd_val + amt_ff};
               res_in    = '{out_key: KEY_FIELD_W'(key_ff), out_value: rd_val + amt_ff,
                             position: POS_W'(mid_ff), existed: 1'b1, status: STATUS_OK};
            end else if (key_ff > rd_key) begin
               lo_in = CW'(mid_ff) + 1'b1;
            end else begin
               hi_in = CW'(mid_ff);
            end
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one slot higher
            mem_we = pend_ff;
            if (ptr_ff > lo_ff) begin
               mem_raddr = AW'(ptr_ff - 1'b1);
               pend_in   = 1'b1;
               waddr_in  = AW'(ptr_ff);
               ptr_in    = ptr_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(lo_ff);
            mem_wdata = {key_ff, amt_ff};
            count_in  = count_ff + 1'b1;
            res_in    = '{out_key: KEY_FIELD_W'(key_ff), out_value: amt_ff,
                          position: POS_W'(lo_ff), existed: 1'b0, status: STATUS_OK};
         end
         ST_READ: begin
            res_in = '{out_key: KEY_FIELD_W'(rd_key), out_value: rd_val,
                       position: POS_W'(idx_ff), existed: 1'b0, status: STATUS_OK};
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, res_ff.status, USED_W'(count_ff), res_ff.existed,
                               res_ff.position, res_ff.out_value, res_ff.out_key};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      amt_ff      <= amt_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ptr_ff      <= ptr_in;
      mid_ff      <= mid_in;
      waddr_ff    <= waddr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/skat_mem.sv =====
// ----------------------------------------------------------------------------
// skat_mem
// Simple dual-port table memory: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module skat_mem #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_sorted_key_accumulate_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_accumulate_table
// Self-checking bench for the sorted key accumulate table.
// ----------------------------------------------------------------------------
// A behavioral copy of the table predicts every result beat. Directed beats
// hit the key, amount and index extremes, wrapping counts, middle inserts and
// out-of-range reads. Random phases mix includes over a small key pool with
// random keys and reads, two of them under uneven idling on both sides.
// One phase holds the receiver off for a long stretch, so the input stalls.
// ----------------------------------------------------------------------------
module tb_sorted_key_accumulate_table
   import skat_pkg::*;
();

   localparam int TABLE_DEPTH   = CAPACITY_DEFAULT;
   localparam int STALL_CYCLES  = 300;
   localparam int DRAIN_TAIL    = 40;
   localparam int IDLE_LIMIT    = 50000;
   localparam int MAX_REPORTS   = 10;
   localparam int POOL_SIZE     = 20;
   localparam int RANDOM_ITEMS  = 37;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0] out_key;
      logic [VAL_W-1:0]       out_value;
      logic [POS_W-1:0]       position;
      logic                   existed;
      logic [USED_W-1:0]      entries_used;
      status_type             status;
   } table_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // key[31:0], amount[63:32], index[75:64], zero pad
   logic [0:0]  req_tuser = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // out_key[31:0], out_value[63:32], position[75:64],
                                  // existed[76], entries_used[89:77], status[91:90], pad

   sorted_key_accumulate_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // shadow table
   logic [KEY_FIELD_W-1:0] shadow_keys [TABLE_DEPTH];
   logic [VAL_W-1:0]       shadow_counts [TABLE_DEPTH];
   int                     shadow_used = 0;

   table_result_type pending_table_results [$];
   logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   logic stall_req = 1'b0;
   logic stall_ack = 1'b0;

   int n_hits = 0, n_inserts = 0, n_refused = 0, n_reads = 0, n_range = 0;

   function automatic table_result_type table_apply(input logic kind,
                                                    input logic [KEY_FIELD_W-1:0] key,
                                                    input logic [VAL_W-1:0] amount,
                                                    input logic [IDX_W-1:0] index);
      table_result_type r;
      int lo, hi, mid, i;
      r = '0;
      if (kind == KIND_READ) begin
         r.position = index;
         r.entries_used = shadow_used[USED_W-1:0];
         if (int'(index) < shadow_used) begin
            r.out_key = shadow_keys[index];
            r.out_value = shadow_counts[index];
            r.status = STATUS_OK;
            n_reads++;
         end else begin
            r.status = STATUS_RANGE;
            n_range++;
         end
         return r;
      end
      lo = 0;
      hi = shadow_used;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_keys[mid] == key) begin
            shadow_counts[mid] = shadow_counts[mid] + amount;
            r.out_key = key;
            r.out_value = shadow_counts[mid];
            r.position = mid[POS_W-1:0];
            r.existed = 1'b1;
            r.entries_used = shadow_used[USED_W-1:0];
            r.status = STATUS_OK;
            n_hits++;
            return r;
         end
         if (key > shadow_keys[mid]) lo = mid + 1;
         else hi = mid;
      end
      r.out_key = key;
      r.position = lo[POS_W-1:0];
      if (shadow_used >= TABLE_DEPTH) begin
         r.entries_used = shadow_used[USED_W-1:0];
         r.status = STATUS_FULL;
         n_refused++;
         return r;
      end
      for (i = shadow_used; i > lo; i--) begin
         shadow_keys[i] = shadow_keys[i-1];
         shadow_counts[i] = shadow_counts[i-1];
      end
      shadow_keys[lo] = key;
      shadow_counts[lo] = amount;
      shadow_used++;
      r.out_value = amount;
      r.entries_used = shadow_used[USED_W-1:0];
      r.status = STATUS_OK;
      n_inserts++;
      return r;
   endfunction

   // Called at a rising edge; returns at the rising edge of acceptance.
   task automatic send_item(input logic kind, input logic [KEY_FIELD_W-1:0] key,
                            input logic [VAL_W-1:0] amount, input logic [IDX_W-1:0] index);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, index, amount, key};
      do @(posedge clock); while (!req_tready);
      pending_table_results.push_back(table_apply(kind, key, amount, index));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_table_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [KEY_FIELD_W-1:0] key;
      logic [VAL_W-1:0] amount;
      logic [IDX_W-1:0] index;
      if ($urandom_range(99) < 62) begin
         key = ($urandom_range(99) < 60) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom();
         case ($urandom_range(9))
            0: amount = 32'h8000_0000;
            1: amount = 32'h7FFF_FFFF;
            2: amount = 32'hFFFF_FFFF;
            default: amount = $urandom();
         endcase
         send_item(KIND_INCLUDE, key, amount, IDX_W'($urandom()));
      end else begin
         if (shadow_used > 0 && $urandom_range(99) < 75)
            index = IDX_W'($urandom_range(shadow_used - 1));
         else
            index = IDX_W'($urandom_range(4095));
         send_item(KIND_READ, $urandom(), $urandom(), index);
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 19;
      recv_idle_pct = 62;
      send_item(KIND_READ, 32'h0, 32'h0, 12'h000);
      send_item(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(KIND_INCLUDE, 32'h8000_0000, 32'h0000_0005, 12'hFFF);
      send_item(KIND_INCLUDE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 12'h000);
      send_item(KIND_INCLUDE, 32'h0000_0000, 32'h8000_0000, 12'h000);
      send_item(KIND_INCLUDE, 32'hFFFF_FFFF, 32'h0000_0001, 12'h000);
      send_item(KIND_INCLUDE, 32'h0000_0000, 32'hFFFF_FFFF, 12'h000);
      send_item(KIND_INCLUDE, 32'h4142_4300, 32'h0000_0010, 12'h000);
      send_item(KIND_INCLUDE, 32'h4100_0000, 32'hFFFF_FFF0, 12'h000);
      send_item(KIND_INCLUDE, 32'hC000_0000, 32'h1234_5678, 12'h000);
      send_item(KIND_INCLUDE, 32'h4142_4300, 32'hFFFF_FFF0, 12'h000);
      send_item(KIND_INCLUDE, 32'h0000_0001, 32'h0000_0000, 12'h000);
      send_item(KIND_READ, 32'h0, 32'h0, 12'h000);
      send_item(KIND_READ, 32'h0, 32'h0, 12'h003);
      send_item(KIND_READ, 32'h0, 32'h0, 12'h006);
      send_item(KIND_READ, 32'h0, 32'h0, 12'h007);
      send_item(KIND_READ, 32'h0, 32'h0, 12'h800);
      send_item(KIND_INCLUDE, 32'h8000_0000, 32'hFFFF_FFFB, 12'h000);
      wait_for_drain();
   endtask

   task automatic test_random(input int s_pct, input int r_pct, input int count);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_random_item();
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_req = 1'b1;
      repeat (12) send_random_item();
      stall_req = 1'b0;
      wait_for_drain();
   endtask

   // receiver: random idling plus one long hold-off on request
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_req && !stall_ack) begin
         rsp_tready <= 1'b0;
         stall_left <= STALL_CYCLES;
         stall_ack <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (!stall_req) stall_ack <= 1'b0;
      end
   end

   always @(posedge clock) begin
      table_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_key = rsp_tdata[31:0];
         got.out_value = rsp_tdata[63:32];
         got.position = rsp_tdata[75:64];
         got.existed = rsp_tdata[76];
         got.entries_used = rsp_tdata[89:77];
         got.status = status_type'(rsp_tdata[91:90]);
         if (pending_table_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result beat with nothing expected: key %h value %h pos %0d",
                        $realtime, got.out_key, got.out_value, got.position);
         end else begin
            want = pending_table_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp key %h val %h pos %0d ex %b used %0d st %0d",
                           $realtime, want.out_key, want.out_value, want.position,
                           want.existed, want.entries_used, want.status);
                  $display("%0t:          got key %h val %h pos %0d ex %b used %0d st %0d",
                           $realtime, got.out_key, got.out_value, got.position,
                           got.existed, got.entries_used, got.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(19, 62, RANDOM_ITEMS);
      test_random(62, 19, RANDOM_ITEMS);
      test_random(0, 0, RANDOM_ITEMS);
      test_backpressure();

      $display("Covered %0d inserts, %0d hits, %0d refused inserts,",
               n_inserts, n_hits, n_refused);
      $display("%0d in-range reads and %0d out-of-range reads; %0d mismatches.",
               n_reads, n_range, mismatch_count);
      if (mismatch_count == 0 && pending_table_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
